// ===== hdl/rdd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the RVL depth decoder.
// Used by the channel interfaces, the decode units and the core top level.
package rdd_pkg;

   localparam int WORD_W       = 32;
   localparam int CODE_W       = 32;
   localparam int PIX_W        = 16;
   localparam int DIM_W        = 16;
   localparam int RUN_W        = 25;
   localparam int KIND_W       = 3;
   localparam int ERR_W        = 3;
   localparam int NIB_W        = 4;
   localparam int POS_W        = 4;
   localparam int SHIFT_W      = POS_W + 2;
   localparam int NIB_IDX_W    = 3;
   localparam int MAX_NIBBLES  = 11;
   localparam int LAST_NIB_IDX = 7;

   typedef enum logic [KIND_W-1:0] {
      KIND_RUN   = 3'd0,
      KIND_PIXEL = 3'd1,
      KIND_SIZE  = 3'd2,
      KIND_END   = 3'd3,
      KIND_ERROR = 3'd4
   } kind_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE     = 3'd0,
      ERR_ZERO_DIM = 3'd1,
      ERR_TOO_BIG  = 3'd2,
      ERR_OVERRUN  = 3'd3,
      ERR_OVERLONG = 3'd4
   } err_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'b001,
      PH_HEIGHT = 3'b010,
      PH_DATA   = 3'b100
   } phase_type;

   typedef enum logic [2:0] {
      EX_ZERO    = 3'b001,
      EX_NONZERO = 3'b010,
      EX_DELTA   = 3'b100
   } expect_type;

   typedef struct packed {
      kind_type              kind;
      logic [PIX_W-1:0]      pixel;
      logic [RUN_W-1:0]      run_length;
      logic [DIM_W-1:0]      width;
      logic [DIM_W-1:0]      height;
      err_type               error_code;
   } res_type;

   typedef struct packed {
      expect_type            expect_kind;
      logic [CODE_W-1:0]     acc;
      logic [POS_W-1:0]      pos;
      logic [PIX_W-1:0]      prev_pixel;
      logic                  end_due;
   } code_state_type;

   typedef struct packed {
      logic res_valid;
      logic stop;
   } step_ctl_type;

endpackage

// ===== hdl/rdd_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the RVL depth decoder.
// Depends on rdd_pkg for field widths.
interface rdd_req_if;
   import rdd_pkg::*;

   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] word;
   logic              restart;

   modport source (output valid, output word, output restart, input ready);
   modport sink (input valid, input word, input restart, output ready);
endinterface

interface rdd_rsp_if;
   import rdd_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [PIX_W-1:0]  pixel;
   logic [RUN_W-1:0]  run_length;
   logic [DIM_W-1:0]  width;
   logic [DIM_W-1:0]  height;
   logic [ERR_W-1:0]  error_code;
   logic              last;

   modport source (output valid, output kind, output pixel, output run_length,
                   output width, output height, output error_code, output last,
                   input ready);
   modport sink (input valid, input kind, input pixel, input run_length,
                 input width, input height, input error_code, input last,
                 output ready);
endinterface

// ===== hdl/rdd_header_check.sv =====
`timescale 1ns / 1ps
// Frame header check: width x height product, zero and size limits.
// Depends on rdd_pkg.
module rdd_header_check #(
   parameter int MAX_PIXELS = 16777216,
   parameter int CNT_W      = 25
) (
   input  logic [rdd_pkg::DIM_W-1:0]  frame_width,
   input  logic                       width_wide,
   input  logic [rdd_pkg::WORD_W-1:0] height_word,
   output rdd_pkg::res_type           res,
   output logic                       ok,
   output logic [CNT_W-1:0]           total
);
   import rdd_pkg::*;

   logic [2*DIM_W-1:0] prod;
   logic               height_wide;

   always_comb begin
      prod        = (2*DIM_W)'(frame_width) * (2*DIM_W)'(height_word[DIM_W-1:0]);
      height_wide = |height_word[WORD_W-1:DIM_W];
      total       = prod[CNT_W-1:0];
      res         = '0;
      ok          = 1'b0;
      if ((frame_width == '0 && !width_wide) || height_word == '0) begin
         res.kind       = KIND_ERROR;
         res.error_code = ERR_ZERO_DIM;
      end else if (width_wide || height_wide || prod > (2*DIM_W)'(MAX_PIXELS)) begin
         res.kind       = KIND_ERROR;
         res.error_code = ERR_TOO_BIG;
      end else begin
         ok         = 1'b1;
         res.kind   = KIND_SIZE;
         res.width  = frame_width;
         res.height = height_word[DIM_W-1:0];
      end
   end

endmodule

// ===== hdl/rdd_nibble_step.sv =====
`timescale 1ns / 1ps
// One nibble of the variable-length code: accumulate, then act on the
// finished zero count, nonzero count or zigzag delta. Depends on rdd_pkg.
module rdd_nibble_step #(
   parameter int CNT_W = 25
) (
   input  logic [rdd_pkg::NIB_W-1:0] nibble,
   input  rdd_pkg::code_state_type   cur,
   input  logic [CNT_W-1:0]          pixels_left,
   input  logic [CNT_W-1:0]          nonzeros_left,
   output rdd_pkg::code_state_type   nxt,
   output logic [CNT_W-1:0]          pixels_left_nxt,
   output logic [CNT_W-1:0]          nonzeros_left_nxt,
   output rdd_pkg::step_ctl_type     ctl,
   output rdd_pkg::res_type          res
);
   import rdd_pkg::*;

   logic [SHIFT_W-1:0] shift_amt;
   logic [CODE_W-1:0]  code_val;
   logic               overrun;
   logic [CNT_W-1:0]   pix_sub;
   logic [CNT_W-1:0]   nz_dec;
   logic [PIX_W-1:0]   delta;
   logic [PIX_W-1:0]   pix_sum;

   always_comb begin
      // 3 * pos without a multiplier
      shift_amt = {2'b00, cur.pos} + {1'b0, cur.pos, 1'b0};
      code_val  = cur.acc | (CODE_W'(nibble[2:0]) << shift_amt);
      overrun   = code_val > CODE_W'(pixels_left);
      pix_sub   = pixels_left - code_val[CNT_W-1:0];
      nz_dec    = (nonzeros_left != '0) ? nonzeros_left - CNT_W'(1) : nonzeros_left;
      delta     = code_val[PIX_W:1] ^ {PIX_W{code_val[0]}};
      pix_sum   = cur.prev_pixel + delta;

      nxt               = cur;
      pixels_left_nxt   = pixels_left;
      nonzeros_left_nxt = nonzeros_left;
      ctl               = '0;
      res               = '0;

      if (cur.end_due) begin
         nxt.end_due   = 1'b0;
         ctl.res_valid = 1'b1;
         ctl.stop      = 1'b1;
         res.kind      = KIND_END;
      end else if (cur.pos >= POS_W'(MAX_NIBBLES)) begin
         ctl.res_valid  = 1'b1;
         ctl.stop       = 1'b1;
         res.kind       = KIND_ERROR;
         res.error_code = ERR_OVERLONG;
      end else if (nibble[NIB_W-1]) begin
         nxt.acc = code_val;
         nxt.pos = cur.pos + POS_W'(1);
      end else begin
         nxt.acc = '0;
         nxt.pos = '0;
         case (cur.expect_kind)
            EX_ZERO: begin
               ctl.res_valid = 1'b1;
               if (overrun) begin
                  ctl.stop       = 1'b1;
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_OVERRUN;
               end else begin
                  pixels_left_nxt = pix_sub;
                  res.kind        = KIND_RUN;
                  res.run_length  = code_val[RUN_W-1:0];
                  nxt.expect_kind = EX_NONZERO;
               end
            end
            EX_NONZERO: begin
               if (overrun) begin
                  ctl.res_valid  = 1'b1;
                  ctl.stop       = 1'b1;
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_OVERRUN;
               end else begin
                  pixels_left_nxt = pix_sub;
                  if (code_val == '0) begin
                     if (pixels_left == '0) begin
                        ctl.res_valid = 1'b1;
                        ctl.stop      = 1'b1;
                        res.kind      = KIND_END;
                     end else begin
                        nxt.expect_kind = EX_ZERO;
                     end
                  end else begin
                     nonzeros_left_nxt = code_val[CNT_W-1:0];
                     nxt.expect_kind   = EX_DELTA;
                  end
               end
            end
            EX_DELTA: begin
               ctl.res_valid     = 1'b1;
               nxt.prev_pixel    = pix_sum;
               res.kind          = KIND_PIXEL;
               res.pixel         = pix_sum;
               nonzeros_left_nxt = nz_dec;
               if (nz_dec == '0) begin
                  // frame end follows the pixel as its own result, from end_due
                  if (pixels_left == '0) begin
                     nxt.end_due = 1'b1;
                  end else begin
                     nxt.expect_kind = EX_ZERO;
                  end
               end
            end
            default: begin
               nxt.expect_kind = EX_ZERO;
            end
         endcase
      end
   end

endmodule

// ===== hdl/rvl_depth_decoder_core.sv =====
`timescale 1ns / 1ps
// RVL depth decoder core. A request carrying restart latches the frame width;
// the next request is the height and yields a frame size item or an error.
// A payload request is decoded one nibble per cycle while the result slots
// have room, eight nibbles in all, plus an extra step for a frame end that
// follows a pixel; a frame end or error ends the request early. The single
// nibble decode step and the result registers pass one item per cycle while
// downstream keeps up. A new request is taken into the input register as
// soon as the previous one is used up, while results still wait downstream.
// Depends on rdd_pkg, rdd_if, rdd_header_check and rdd_nibble_step.
module rvl_depth_decoder_core #(
   parameter int MAX_PIXELS = 16777216
) (
   input  logic      clock,
   input  logic      reset,
   rdd_req_if.sink   req_chan,
   rdd_rsp_if.source rsp_chan
);
   import rdd_pkg::*;

   localparam int CNT_W = $clog2(longint'(MAX_PIXELS) + 1);

   logic                 in_valid_ff, in_valid_in;
   logic [WORD_W-1:0]    in_word_ff, in_word_in;
   logic                 in_restart_ff, in_restart_in;
   logic [NIB_IDX_W-1:0] nib_idx_ff, nib_idx_in;

   phase_type            phase_ff, phase_in;
   logic [DIM_W-1:0]     frame_width_ff, frame_width_in;
   logic                 width_wide_ff, width_wide_in;
   code_state_type       code_ff, code_in;
   logic [CNT_W-1:0]     pix_left_ff, pix_left_in;
   logic [CNT_W-1:0]     nz_left_ff, nz_left_in;

   logic                 pend_valid_ff, pend_valid_in;
   logic                 pend_last_ff, pend_last_in;
   res_type              pend_res_ff, pend_res_in;

   logic                 out_valid_ff, out_valid_in;
   logic                 out_last_ff, out_last_in;
   res_type              out_res_ff, out_res_in;

   res_type              hdr_res;
   logic                 hdr_ok;
   logic [CNT_W-1:0]     hdr_total;

   code_state_type       step_nxt;
   logic [CNT_W-1:0]     step_pix_left;
   logic [CNT_W-1:0]     step_nz_left;
   step_ctl_type         step_ctl;
   res_type              step_res;

   logic                 r_valid;
   res_type              r_res;
   logic                 word_done;
   logic                 can_push;
   logic                 room;
   logic                 engine_go;
   logic                 consume;
   logic                 push_pend;
   code_state_type       code_clear;

   rdd_header_check #(
      .MAX_PIXELS (MAX_PIXELS),
      .CNT_W      (CNT_W)
   ) u_header (
      .frame_width (frame_width_ff),
      .width_wide  (width_wide_ff),
      .height_word (in_word_ff),
      .res         (hdr_res),
      .ok          (hdr_ok),
      .total       (hdr_total)
   );

   rdd_nibble_step #(
      .CNT_W (CNT_W)
   ) u_step (
      .nibble            (in_word_ff[WORD_W-1 -: NIB_W]),
      .cur               (code_ff),
      .pixels_left       (pix_left_ff),
      .nonzeros_left     (nz_left_ff),
      .nxt               (step_nxt),
      .pixels_left_nxt   (step_pix_left),
      .nonzeros_left_nxt (step_nz_left),
      .ctl               (step_ctl),
      .res               (step_res)
   );

   // What the current request does this cycle
   always_comb begin
      r_valid   = 1'b0;
      r_res     = '0;
      word_done = 1'b1;
      if (!in_restart_ff) begin
         case (phase_ff)
            PH_HEIGHT: begin
               r_valid = 1'b1;
               r_res   = hdr_res;
            end
            PH_DATA: begin
               r_valid   = step_ctl.res_valid;
               r_res     = step_res;
               word_done = step_ctl.stop ||
                           (nib_idx_ff == NIB_IDX_W'(LAST_NIB_IDX) &&
                            !code_ff.end_due && !step_nxt.end_due);
            end
            default: begin
               word_done = 1'b1;
            end
         endcase
      end
   end

   assign can_push       = !out_valid_ff || rsp_chan.ready;
   assign room           = !pend_valid_ff || can_push;
   assign engine_go      = in_valid_ff && (!r_valid || room);
   assign consume        = engine_go && word_done;
   assign push_pend      = pend_valid_ff && can_push &&
                           (pend_last_ff || (engine_go && r_valid));
   assign req_chan.ready = !in_valid_ff || consume;

   always_comb begin
      code_clear             = '0;
      code_clear.expect_kind = EX_ZERO;
      code_clear.prev_pixel  = code_ff.prev_pixel;
   end

   // Decoder state
   always_comb begin
      phase_in       = phase_ff;
      frame_width_in = frame_width_ff;
      width_wide_in  = width_wide_ff;
      code_in        = code_ff;
      pix_left_in    = pix_left_ff;
      nz_left_in     = nz_left_ff;
      if (engine_go) begin
         if (in_restart_ff) begin
            frame_width_in = in_word_ff[DIM_W-1:0];
            width_wide_in  = |in_word_ff[WORD_W-1:DIM_W];
            phase_in       = PH_HEIGHT;
         end else begin
            case (phase_ff)
               PH_HEIGHT: begin
                  if (hdr_ok) begin
                     phase_in           = PH_DATA;
                     code_in            = '0;
                     code_in.expect_kind = EX_ZERO;
                     pix_left_in        = hdr_total;
                     nz_left_in         = '0;
                  end else begin
                     phase_in = PH_IDLE;
                  end
               end
               PH_DATA: begin
                  pix_left_in = step_pix_left;
                  if (step_ctl.stop) begin
                     phase_in   = PH_IDLE;
                     code_in    = code_clear;
                     nz_left_in = '0;
                  end else begin
                     code_in    = step_nxt;
                     nz_left_in = step_nz_left;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   // Input register: load a new request, or advance to the next nibble
   always_comb begin
      in_valid_in   = in_valid_ff;
      in_word_in    = in_word_ff;
      in_restart_in = in_restart_ff;
      nib_idx_in    = nib_idx_ff;
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in   = 1'b1;
         in_word_in    = req_chan.word;
         in_restart_in = req_chan.restart;
         nib_idx_in    = '0;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end else if (engine_go && !in_restart_ff && phase_ff == PH_DATA &&
                   !code_ff.end_due) begin
         in_word_in = {in_word_ff[WORD_W-NIB_W-1:0], {NIB_W{1'b0}}};
         nib_idx_in = nib_idx_ff + NIB_IDX_W'(1);
      end
   end

   // Hold the newest result until the request's next result or its end decides last
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_last_in  = pend_last_ff;
      pend_res_in   = pend_res_ff;
      if (engine_go && r_valid) begin
         pend_valid_in = 1'b1;
         pend_last_in  = word_done;
         pend_res_in   = r_res;
      end else if (push_pend) begin
         pend_valid_in = 1'b0;
         pend_last_in  = 1'b0;
      end else if (engine_go && word_done && pend_valid_ff) begin
         pend_last_in = 1'b1;
      end
   end

   always_comb begin
      out_res_in  = out_res_ff;
      out_last_in = out_last_ff;
      if (push_pend) begin
         out_valid_in = 1'b1;
         out_res_in   = pend_res_ff;
         out_last_in  = pend_last_ff;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         nib_idx_ff    <= '0;
         phase_ff      <= PH_IDLE;
         code_ff       <= '{expect_kind: EX_ZERO, acc: '0, pos: '0, prev_pixel: '0,
                            end_due: 1'b0};
         pend_valid_ff <= 1'b0;
         pend_last_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         nib_idx_ff    <= nib_idx_in;
         phase_ff      <= phase_in;
         code_ff       <= code_in;
         pend_valid_ff <= pend_valid_in;
         pend_last_ff  <= pend_last_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_word_ff     <= in_word_in;
      in_restart_ff  <= in_restart_in;
      frame_width_ff <= frame_width_in;
      width_wide_ff  <= width_wide_in;
      pix_left_ff    <= pix_left_in;
      nz_left_ff     <= nz_left_in;
      pend_res_ff    <= pend_res_in;
      out_res_ff     <= out_res_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.kind       = out_res_ff.kind;
   assign rsp_chan.pixel      = out_res_ff.pixel;
   assign rsp_chan.run_length = out_res_ff.run_length;
   assign rsp_chan.width      = out_res_ff.width;
   assign rsp_chan.height     = out_res_ff.height;
   assign rsp_chan.error_code = out_res_ff.error_code;
   assign rsp_chan.last       = out_last_ff;

   a_pend_last_valid: assert property (@(posedge clock) disable iff (reset)
      pend_last_ff |-> pend_valid_ff)
      else $error("closing flag set on an empty result slot");

   a_open_result_has_request: assert property (@(posedge clock) disable iff (reset)
      (pend_valid_ff && !pend_last_ff) |-> in_valid_ff)
      else $error("open result left behind after its request was used up");

   a_end_due_in_data: assert property (@(posedge clock) disable iff (reset)
      code_ff.end_due |-> (phase_ff == PH_DATA))
      else $error("frame end pending outside the payload phase");

   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      code_ff.pos <= POS_W'(MAX_NIBBLES))
      else $error("code nibble position beyond its limit");

endmodule
